// ===== sv/swf_pkg.sv =====
// Shared types and codes for the LIFO stack with flip and indexed read.
// No dependencies; used by swf_ctrl and stack_with_flip_and_index.
package swf_pkg;

  localparam int SWF_DEPTH  = 256;
  localparam int SWF_DATA_W = 8;
  localparam int SWF_POS_W  = 9;
  localparam int SWF_CNT_W  = 9;
  localparam int SWF_ACT_W  = 3;
  localparam int SWF_STS_W  = 2;

  localparam logic [SWF_ACT_W-1:0] ACT_PUSH  = 3'd0;
  localparam logic [SWF_ACT_W-1:0] ACT_POP   = 3'd1;
  localparam logic [SWF_ACT_W-1:0] ACT_PEEK  = 3'd2;
  localparam logic [SWF_ACT_W-1:0] ACT_READ  = 3'd3;
  localparam logic [SWF_ACT_W-1:0] ACT_FLIP  = 3'd4;
  localparam logic [SWF_ACT_W-1:0] ACT_CLEAR = 3'd5;

  localparam logic [SWF_STS_W-1:0] STS_OK    = 2'd0;
  localparam logic [SWF_STS_W-1:0] STS_FULL  = 2'd1;
  localparam logic [SWF_STS_W-1:0] STS_EMPTY = 2'd2;
  localparam logic [SWF_STS_W-1:0] STS_RANGE = 2'd3;

  typedef struct packed {
    logic [SWF_ACT_W-1:0]  action;
    logic [SWF_DATA_W-1:0] push_value;
    logic [SWF_POS_W-1:0]  position;
  } swf_req_t;

  typedef struct packed {
    logic [SWF_DATA_W-1:0] read_value;
    logic [SWF_STS_W-1:0]  status;
    logic [SWF_CNT_W-1:0]  entry_count;
    logic                  is_empty;
  } swf_rsp_t;

endpackage

// ===== sv/swf_ram.sv =====
// Generic single-port synchronous RAM with registered read data.
// No dependencies.
module swf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                                  clk,
  input  logic                                  en,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                      wdata,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

// ===== sv/swf_ctrl.sv =====
// Stack control: count, bottom slot and direction, slot address math,
// RAM request and registered result fields. Depends on swf_pkg.
module swf_ctrl #(
  parameter int DEPTH = swf_pkg::SWF_DEPTH
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       start,
  input  swf_pkg::swf_req_t                          req,
  output logic                                       busy,
  output logic                                       mem_en,
  output logic                                       mem_we,
  output logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] mem_addr,
  output logic [swf_pkg::SWF_DATA_W-1:0]             mem_wdata,
  output logic                                       done,
  output logic                                       rd_sel,
  output logic [swf_pkg::SWF_STS_W-1:0]              status,
  output logic [swf_pkg::SWF_CNT_W-1:0]              entry_count,
  output logic                                       is_empty
);
  import swf_pkg::*;

  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int CMP_W = (CW > SWF_POS_W) ? CW : SWF_POS_W;

  logic [CW-1:0]        count, count_next;
  logic [AW-1:0]        bottom, bottom_next;
  logic                 reversed, reversed_next;

  logic                 accept;
  logic [CMP_W-1:0]     pos_ext, cnt_ext, pos_m1;
  logic [CW-1:0]        cnt_m1;
  logic [AW-1:0]        offset;
  logic [AW:0]          slot_sum;
  logic [AW-1:0]        slot;
  logic                 pos_ok;
  logic [SWF_STS_W-1:0] status_next;
  logic                 rd_next;

  assign accept  = start && !busy;
  assign pos_ext = CMP_W'(req.position);
  assign cnt_ext = CMP_W'(count);
  assign pos_m1  = pos_ext - CMP_W'(1);
  assign cnt_m1  = count - CW'(1);
  assign pos_ok  = (pos_ext != '0) && (pos_ext <= cnt_ext);

  // offset from the bottom of the entry this request touches
  always_comb begin
    case (req.action)
      ACT_PUSH: offset = count[AW-1:0];
      ACT_READ: offset = pos_m1[AW-1:0];
      default:  offset = cnt_m1[AW-1:0];
    endcase
  end

  // circular slot: both forms land in [0, 2*DEPTH), one subtract reduces
  always_comb begin
    if (reversed) begin
      slot_sum = {1'b0, bottom} + (AW+1)'(DEPTH) - {1'b0, offset};
    end else begin
      slot_sum = {1'b0, bottom} + {1'b0, offset};
    end
    if (slot_sum >= (AW+1)'(DEPTH)) begin
      slot = AW'(slot_sum - (AW+1)'(DEPTH));
    end else begin
      slot = slot_sum[AW-1:0];
    end
  end

  always_comb begin
    count_next    = count;
    bottom_next   = bottom;
    reversed_next = reversed;
    status_next   = STS_OK;
    rd_next       = 1'b0;
    mem_en        = 1'b0;
    mem_we        = 1'b0;
    mem_addr      = slot;
    mem_wdata     = req.push_value;
    unique case (req.action)
      ACT_PUSH: begin
        if (count == CW'(DEPTH)) begin
          status_next = STS_FULL;
        end else begin
          mem_en     = accept;
          mem_we     = 1'b1;
          count_next = count + CW'(1);
        end
      end
      ACT_POP, ACT_PEEK: begin
        if (count == '0) begin
          status_next = STS_EMPTY;
        end else begin
          mem_en  = accept;
          rd_next = 1'b1;
          if (req.action == ACT_POP) begin
            count_next = cnt_m1;
          end
        end
      end
      ACT_READ: begin
        if (!pos_ok) begin
          status_next = STS_RANGE;
        end else begin
          mem_en  = accept;
          rd_next = 1'b1;
        end
      end
      ACT_FLIP: begin
        if (count != '0) begin
          bottom_next = slot;
        end
        reversed_next = !reversed;
      end
      ACT_CLEAR: begin
        count_next    = '0;
        bottom_next   = '0;
        reversed_next = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      done     <= 1'b0;
      rd_sel   <= 1'b0;
      count    <= '0;
      bottom   <= '0;
      reversed <= 1'b0;
    end else begin
      busy   <= 1'b0;
      done   <= accept;
      rd_sel <= accept && rd_next;
      if (accept) begin
        count    <= count_next;
        bottom   <= bottom_next;
        reversed <= reversed_next;
      end
    end
  end

  // result fields; read data joins from the RAM in the top level
  always_ff @(posedge clk) begin
    if (accept) begin
      status      <= status_next;
      entry_count <= SWF_CNT_W'(count_next);
      is_empty    <= (count_next == '0);
    end
  end

endmodule

// ===== sv/stack_with_flip_and_index.sv =====
// Top level of the LIFO stack with order flip and indexed read.
// Depends on swf_pkg, swf_ctrl and swf_ram.
//
// Usage:
//   Request channel: drive req and raise start; the request transfers on a
//   rising edge where start is high and busy is low. Actions are push, pop,
//   peek, read at a position from the bottom, flip order and clear.
//   Result channel: done is high for exactly one cycle, the cycle after the
//   transfer, with rsp valid in that cycle. Every request gives one result.
//   One request can transfer every cycle while busy is low. This is
//   allowed by the single RAM port: each request makes at most one access,
//   and the read data comes out of the RAM's output register.
//   A flip only moves the bottom slot to the old top (if the stack is not
//   empty) and inverts the direction, so it makes no RAM access.
//   Reset (rst, synchronous) empties the stack; RAM contents are not
//   cleared and are never read before being written. busy is high while
//   rst is applied and for the cycle after.
//   The receiver cannot stall: a result not taken in its cycle is lost.
module stack_with_flip_and_index #(
  parameter int DEPTH = swf_pkg::SWF_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  swf_pkg::swf_req_t req,
  output logic              busy,
  output logic              done,
  output swf_pkg::swf_rsp_t rsp
);
  import swf_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic                  mem_en;
  logic                  mem_we;
  logic [AW-1:0]         mem_addr;
  logic [SWF_DATA_W-1:0] mem_wdata;
  logic [SWF_DATA_W-1:0] mem_rdata;
  logic                  rd_sel;
  logic [SWF_STS_W-1:0]  status;
  logic [SWF_CNT_W-1:0]  entry_count;
  logic                  is_empty;

  swf_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .req        (req),
    .busy       (busy),
    .mem_en     (mem_en),
    .mem_we     (mem_we),
    .mem_addr   (mem_addr),
    .mem_wdata  (mem_wdata),
    .done       (done),
    .rd_sel     (rd_sel),
    .status     (status),
    .entry_count(entry_count),
    .is_empty   (is_empty)
  );

  swf_ram #(
    .WIDTH(SWF_DATA_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .en   (mem_en),
    .we   (mem_we),
    .addr (mem_addr),
    .wdata(mem_wdata),
    .rdata(mem_rdata)
  );

  always_comb begin
    rsp.read_value  = rd_sel ? mem_rdata : '0;
    rsp.status      = status;
    rsp.entry_count = entry_count;
    rsp.is_empty    = is_empty;
  end

endmodule

// ===== test/swf_stack_checker.sv =====
`timescale 1ns / 1ps
// Checker for stack_with_flip_and_index: keeps its own copy of the stack,
// works out the answer to each request transfer and compares every result.
// Depends on swf_pkg.
module swf_stack_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              busy,
  input  swf_pkg::swf_req_t req,
  input  logic              done,
  input  swf_pkg::swf_rsp_t rsp,
  output int                pending,
  output int                checked,
  output int                errors
);
  import swf_pkg::*;

  localparam int SLOT_W = $clog2(SWF_DEPTH);

  logic [SWF_DATA_W-1:0] slots [SWF_DEPTH];
  int                    depth_used = 0;
  logic [SLOT_W-1:0]     bottom = '0;
  logic                  downward = 1'b0;
  swf_rsp_t              answers [$];
  int                    err_n = 0;
  int                    chk_n = 0;

  // offset counted from the bottom entry, wraps around the slot ring
  function automatic logic [SLOT_W-1:0] slot_at(int offs);
    logic [SLOT_W-1:0] o;
    o = offs[SLOT_W-1:0];
    return downward ? bottom - o : bottom + o;
  endfunction

  function automatic swf_rsp_t apply_request(swf_req_t r);
    swf_rsp_t a;
    int       p;
    a = '0;
    a.status = STS_OK;
    p = r.position;
    case (r.action)
      ACT_PUSH: begin
        if (depth_used >= SWF_DEPTH) begin
          a.status = STS_FULL;
        end else begin
          slots[slot_at(depth_used)] = r.push_value;
          depth_used++;
        end
      end
      ACT_POP, ACT_PEEK: begin
        if (depth_used == 0) begin
          a.status = STS_EMPTY;
        end else begin
          a.read_value = slots[slot_at(depth_used - 1)];
          if (r.action == ACT_POP) depth_used--;
        end
      end
      ACT_READ: begin
        if (p < 1 || p > depth_used) a.status = STS_RANGE;
        else a.read_value = slots[slot_at(p - 1)];
      end
      ACT_FLIP: begin
        // old top becomes the bottom, direction inverts
        if (depth_used > 0) bottom = slot_at(depth_used - 1);
        downward = ~downward;
      end
      ACT_CLEAR: begin
        depth_used = 0;
        bottom = '0;
        downward = 1'b0;
      end
      default: ;
    endcase
    a.entry_count = depth_used[SWF_CNT_W-1:0];
    a.is_empty = (depth_used == 0);
    return a;
  endfunction

  task automatic note_field(string nm, int want, int got);
    if (want != got) begin
      err_n++;
      $display("%0t ns: result %0d, %s mismatch: expected %0d, got %0d",
               $time, chk_n, nm, want, got);
    end
  endtask

  always @(posedge clk) begin
    swf_rsp_t want;
    if (rst) begin
      depth_used = 0;
      bottom = '0;
      downward = 1'b0;
      answers.delete();
    end else begin
      // result of the previous transfer first, then the new transfer
      if (done) begin
        if (answers.size() == 0) begin
          err_n++;
          $display("%0t ns: result with nothing expected: value %0d status %0d count %0d",
                   $time, rsp.read_value, rsp.status, rsp.entry_count);
        end else begin
          want = answers.pop_front();
          chk_n++;
          note_field("read_value", want.read_value, rsp.read_value);
          note_field("status", want.status, rsp.status);
          note_field("entry_count", want.entry_count, rsp.entry_count);
          note_field("is_empty", want.is_empty, rsp.is_empty);
        end
      end
      if (start && !busy) answers.push_back(apply_request(req));
    end
    pending <= answers.size();
    checked <= chk_n;
    errors <= err_n;
  end

endmodule

// ===== test/stack_with_flip_and_index_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for stack_with_flip_and_index: drives directed and random
// request transfers in bursts; checking is done by swf_stack_checker.
// Depends on swf_pkg, swf_stack_checker and the block itself.
module stack_with_flip_and_index_tb;
  import swf_pkg::*;

  localparam int ITEMS    = 1700;
  localparam int WATCHDOG = 2000;

  // codes the block must ignore
  localparam logic [SWF_ACT_W-1:0] ACT_SPARE_LO = 3'd6;
  localparam logic [SWF_ACT_W-1:0] ACT_SPARE_HI = 3'd7;

  typedef enum {TREND_MIX, TREND_GROW, TREND_SHRINK} trend_e;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     start = 1'b0;
  swf_req_t req = '0;
  logic     busy;
  logic     done;
  swf_rsp_t rsp;
  int       pending;
  int       checked;
  int       errors;

  int     level = 0;
  int     sent = 0;
  int     fills = 0;
  int     burst_left = 0;
  int     trend_left = 0;
  int     quiet = 0;
  trend_e trend = TREND_MIX;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  stack_with_flip_and_index i_dut (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .req   (req),
    .busy  (busy),
    .done  (done),
    .rsp   (rsp)
  );

  swf_stack_checker i_check (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .req     (req),
    .done    (done),
    .rsp     (rsp),
    .pending (pending),
    .checked (checked),
    .errors  (errors)
  );

  function automatic swf_req_t make_req(logic [SWF_ACT_W-1:0] act,
                                        logic [SWF_DATA_W-1:0] val,
                                        logic [SWF_POS_W-1:0] pos);
    swf_req_t r;
    r.action = act;
    r.push_value = val;
    r.position = pos;
    return r;
  endfunction

  // mostly valid positions, plus zero, one past the top and raw noise
  function automatic logic [SWF_POS_W-1:0] pick_position();
    int k;
    k = $urandom_range(0, 9);
    if (level > 0 && k < 7) return SWF_POS_W'($urandom_range(1, level));
    if (k == 7) return '0;
    if (k == 8) return SWF_POS_W'(level + 1);
    return SWF_POS_W'($urandom);
  endfunction

  function automatic swf_req_t random_req();
    int                    pw;
    int                    qw;
    int                    w;
    int                    v;
    logic [SWF_DATA_W-1:0] val;
    logic [SWF_POS_W-1:0]  junk;
    val = SWF_DATA_W'($urandom);
    junk = SWF_POS_W'($urandom);
    case (trend)
      TREND_GROW:   begin pw = 60; qw = 10; end
      TREND_SHRINK: begin pw = 15; qw = 45; end
      default:      begin pw = 35; qw = 25; end
    endcase
    w = $urandom_range(0, 99);
    if (w < pw) return make_req(ACT_PUSH, val, junk);
    if (w < pw + qw) return make_req(ACT_POP, val, junk);
    v = $urandom_range(0, 99);
    if (v < 50) return make_req(ACT_READ, val, pick_position());
    if (v < 70) return make_req(ACT_PEEK, val, junk);
    if (v < 90) return make_req(ACT_FLIP, val, junk);
    if (v < 93) return make_req(ACT_CLEAR, val, junk);
    if (v < 96) return make_req(ACT_SPARE_LO, val, junk);
    return make_req(ACT_SPARE_HI, val, junk);
  endfunction

  // one transfer; start stays high inside a burst, gaps come between bursts
  task automatic issue(swf_req_t r);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk);
        start <= 1'b0;
      end
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 12);
    end
    burst_left--;
    @(negedge clk);
    start <= 1'b1;
    req <= r;
    do @(posedge clk); while (busy);
    sent++;
    case (r.action)
      ACT_PUSH:  if (level < SWF_DEPTH) level++;
      ACT_POP:   if (level > 0) level--;
      ACT_CLEAR: level = 0;
      default: ;
    endcase
  endtask

  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic fill_and_probe(bit empty_out);
    while (level < SWF_DEPTH)
      issue(make_req(ACT_PUSH, SWF_DATA_W'($urandom), SWF_POS_W'($urandom)));
    fills++;
    issue(make_req(ACT_PUSH, 8'h3c, '0));
    issue(make_req(ACT_PUSH, 8'hc3, '1));
    issue(make_req(ACT_READ, '0, SWF_POS_W'(SWF_DEPTH)));
    issue(make_req(ACT_READ, '0, SWF_POS_W'(SWF_DEPTH + 1)));
    issue(make_req(ACT_PEEK, '0, '0));
    issue(make_req(ACT_FLIP, '0, '0));
    issue(make_req(ACT_READ, '0, 9'd1));
    issue(make_req(ACT_READ, '0, SWF_POS_W'(SWF_DEPTH)));
    issue(make_req(ACT_PEEK, '0, '0));
    if (empty_out) begin
      while (level > 0) issue(make_req(ACT_POP, '0, '0));
      issue(make_req(ACT_POP, '0, '0));
      issue(make_req(ACT_PEEK, '0, '0));
    end
  endtask

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= WATCHDOG) begin
        $display("Watchdog: %0d cycles without a transfer, %0d results outstanding",
                 quiet, pending);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // empty store, ignored codes, then a small stack with flip and clear
    issue(make_req(ACT_POP, '0, '0));
    issue(make_req(ACT_PEEK, '1, '1));
    issue(make_req(ACT_READ, '0, '0));
    issue(make_req(ACT_READ, '0, 9'd1));
    issue(make_req(ACT_READ, '0, '1));
    issue(make_req(ACT_FLIP, '0, '0));
    issue(make_req(ACT_SPARE_LO, 8'h77, 9'd3));
    issue(make_req(ACT_SPARE_HI, '1, '1));
    issue(make_req(ACT_PUSH, 8'h00, '0));
    issue(make_req(ACT_PUSH, 8'hff, '1));
    issue(make_req(ACT_PUSH, 8'ha5, '0));
    issue(make_req(ACT_PUSH, 8'h5a, '0));
    issue(make_req(ACT_PEEK, '0, '0));
    issue(make_req(ACT_READ, '0, 9'd1));
    issue(make_req(ACT_READ, '0, 9'd4));
    issue(make_req(ACT_READ, '0, 9'd5));
    issue(make_req(ACT_READ, '0, '0));
    issue(make_req(ACT_FLIP, '0, '0));
    issue(make_req(ACT_READ, '0, 9'd1));
    issue(make_req(ACT_PEEK, '0, '0));
    issue(make_req(ACT_POP, '0, '0));
    issue(make_req(ACT_READ, '0, 9'd3));
    issue(make_req(ACT_CLEAR, '0, '0));
    issue(make_req(ACT_POP, '0, '0));
    issue(make_req(ACT_READ, '0, 9'd1));
    drain();

    while (sent < ITEMS) begin
      if (sent >= 300 && fills == 0) begin
        fill_and_probe(1'b1);
      end else if (sent >= 1000 && fills == 1) begin
        drain();
        fill_and_probe(1'b0);
      end else begin
        if (trend_left == 0) begin
          trend = trend_e'($urandom_range(0, 2));
          trend_left = $urandom_range(20, 80);
        end
        trend_left--;
        issue(random_req());
      end
    end

    drain();
    repeat (4) @(negedge clk);

    $display("Sent %0d requests and checked %0d results across all actions and unused codes,",
             sent, checked);
    $display("with overflow, underflow, bad positions and flips; full depth reached %0d times.",
             fills);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", errors);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
